// ===== hdl/ifst_pkg.sv =====
// Package for the IMU frame sync trigger: payload structs, frame constants, status codes.
// No dependencies.
`timescale 1ns / 1ps
package ifst_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] timestamp;
    logic        report_due;
    logic [6:0]  camera_lines;
    logic        lidar_line;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_BAD_SUM = 3'd2,
    ST_SHORT   = 3'd3,
    ST_NOSTAMP = 3'd4,
    ST_OTHER   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MOD  = 2'd1,
    S_OUT  = 2'd2
  } state_e;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned LidarReg  = 7;
  localparam logic [7:0]  Preamble0 = 8'hFA;
  localparam logic [7:0]  Preamble1 = 8'hFF;
  localparam logic [7:0]  MsgTime   = 8'h36;
  localparam logic [7:0]  Head0     = 8'h10;
  localparam logic [7:0]  Head1     = 8'h20;
  localparam logic [7:0]  Head2     = 8'h02;
  localparam logic [15:0] LidarHigh = 16'd10;
  localparam logic [15:0] CamReset  = 16'd25;
  localparam logic [15:0] LidarRst  = 16'd400;

endpackage

// ===== hdl/imu_frame_sync_trigger.sv =====
// Top level of the IMU frame sync trigger: frame parser, tick extension and trigger lines.
// Depends on ifst_pkg.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_item_i  (ifst_pkg::in_item_t)
//  output  | out_valid | out_stall | out_item_o (ifst_pkg::out_item_t)
//  config  | cfg_we_i  | -         | cfg_idx_i / cfg_data_i
//
// A sync pulse loads stamp+1 into the shared dividend register and shifts it,
// bit-serially, through 32 restoring steps, all eight divisors sharing the same
// dividend bit each step, then applies the remainders to the lines. Reset
// clears all control state. A held result stalls intake only.
`timescale 1ns / 1ps
module imu_frame_sync_trigger #(
  parameter int unsigned NUM_CAMERAS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ifst_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ifst_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned NumDiv = ifst_pkg::NumRegs;

  ifst_pkg::state_e state_q, state_d;

  logic [15:0] div_q [NumDiv];
  logic [15:0] rem_q [NumDiv];
  logic [16:0] rem_sh [NumDiv];
  logic [31:0] dvd_q;
  logic [4:0]  cnt_q;

  logic [8:0]  pos_q;
  logic [7:0]  len_q, sum_q, id_q;
  logic [7:0]  head_q [5];
  logic [15:0] tick_q, wrap_q;
  logic [31:0] stamp_q;
  logic        pend_q;
  logic [6:0]  cam_q;
  logic        lid_q;
  logic [2:0]  st_q;
  logic        rep_q;
  logic        out_v_q;

  logic        acc;
  assign in_stall_o  = (state_q != ifst_pkg::S_IDLE) || out_v_q;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;

  always_comb begin
    out_item_o.status       = st_q;
    out_item_o.timestamp    = stamp_q;
    out_item_o.report_due   = rep_q;
    out_item_o.camera_lines = cam_q;
    out_item_o.lidar_line   = lid_q;
  end

  // byte parser, combinational next values
  logic [8:0]  pos1;
  logic [7:0]  b, sum_n, id_n, len_n;
  logic [8:0]  pos_n;
  logic [2:0]  st_n;
  logic        end_f, take_f;
  logic [15:0] t_new;
  logic [7:0]  h [5];
  always_comb begin
    b     = in_item_i.rx_byte;
    pos1  = pos_q + 9'd1;
    pos_n = pos1;
    sum_n = sum_q + b;
    id_n  = id_q;
    len_n = len_q;
    end_f = 1'b0;
    for (int k = 0; k < 5; k++) h[k] = head_q[k];
    if (pos1 == 9'd1) begin
      sum_n = 8'd0;
      if (b != ifst_pkg::Preamble0) pos_n = 9'd0;
    end else if (pos1 == 9'd2) begin
      if (b != ifst_pkg::Preamble1) pos_n = 9'd0;
    end else if (pos1 == 9'd3) begin
      id_n = b;
    end else if (pos1 == 9'd4) begin
      len_n = b;
    end else begin
      if (pos1 < 9'd10) h[3'(pos1 - 9'd5)] = b;
      if (pos1 >= 9'd5 + {1'b0, len_q}) begin
        end_f = 1'b1;
        pos_n = 9'd0;
      end
    end
    t_new  = {h[3], h[4]};
    take_f = 1'b0;
    st_n   = ifst_pkg::ST_NONE;
    if (end_f) begin
      if (sum_n != 8'd0) st_n = ifst_pkg::ST_BAD_SUM;
      else if (id_q != ifst_pkg::MsgTime) st_n = ifst_pkg::ST_OTHER;
      else if (len_q < 8'd5) st_n = ifst_pkg::ST_SHORT;
      else if (h[0] != ifst_pkg::Head0 || h[1] != ifst_pkg::Head1 ||
               h[2] != ifst_pkg::Head2) st_n = ifst_pkg::ST_NOSTAMP;
      else begin
        st_n   = ifst_pkg::ST_TAKEN;
        take_f = 1'b1;
      end
    end
  end

  // one restoring step per divisor: shift in the next dividend bit
  logic [15:0] rem_nx [NumDiv];
  always_comb begin
    for (int i = 0; i < NumDiv; i++) begin
      rem_sh[i] = {rem_q[i], dvd_q[31]};
      if (rem_sh[i] >= {1'b0, div_q[i]}) rem_nx[i] = 16'(rem_sh[i] - {1'b0, div_q[i]});
      else rem_nx[i] = rem_sh[i][15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ifst_pkg::S_IDLE: if (acc && in_item_i.req_type) state_d = ifst_pkg::S_MOD;
      ifst_pkg::S_MOD:  if (cnt_q == 5'd31) state_d = ifst_pkg::S_OUT;
      ifst_pkg::S_OUT:  state_d = ifst_pkg::S_IDLE;
      default:          state_d = ifst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifst_pkg::S_IDLE;
      for (int i = 0; i < NumDiv; i++)
        div_q[i] <= (i == ifst_pkg::LidarReg) ? ifst_pkg::LidarRst : ifst_pkg::CamReset;
      pos_q <= '0; len_q <= '0; sum_q <= '0; id_q <= '0;
      tick_q <= '0; wrap_q <= '0; stamp_q <= '0; pend_q <= 1'b0;
      cam_q <= '0; lid_q <= 1'b0; st_q <= '0; rep_q <= 1'b0;
      out_v_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) div_q[cfg_idx_i] <= cfg_data_i;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (acc && !in_item_i.req_type) begin
        pos_q <= pos_n; sum_q <= sum_n; id_q <= id_n; len_q <= len_n;
        st_q  <= st_n;
        rep_q <= take_f && pend_q;
        if (take_f) begin
          pend_q <= 1'b0;
          tick_q <= t_new;
          if (t_new < tick_q) begin
            wrap_q  <= wrap_q + 16'd1;
            stamp_q <= {wrap_q + 16'd1, t_new};
          end else stamp_q <= {wrap_q, t_new};
        end
        out_v_q <= 1'b1;
      end
      if (acc && in_item_i.req_type) cnt_q <= '0;
      if (state_q == ifst_pkg::S_MOD) cnt_q <= cnt_q + 5'd1;
      if (state_q == ifst_pkg::S_OUT) begin
        // apply remainders to the lines
        for (int i = 0; i < 7; i++) begin
          if (i < NUM_CAMERAS && div_q[i] != 16'd0) begin
            if (rem_q[i] == 16'd0) cam_q[i] <= 1'b1;
            else if (rem_q[i] == 16'd1) cam_q[i] <= 1'b0;
          end
        end
        if (div_q[ifst_pkg::LidarReg] != 16'd0) begin
          if (rem_q[ifst_pkg::LidarReg] == 16'd0) begin
            lid_q  <= 1'b0;
            pend_q <= 1'b1;
          end else if (rem_q[ifst_pkg::LidarReg] == ifst_pkg::LidarHigh) lid_q <= 1'b1;
        end
        st_q    <= ifst_pkg::ST_NONE;
        rep_q   <= 1'b0;
        out_v_q <= 1'b1;
      end
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    if (acc && !in_item_i.req_type) begin
      for (int k = 0; k < 5; k++) head_q[k] <= h[k];
    end
    if (acc && in_item_i.req_type) begin
      dvd_q <= stamp_q + 32'd1;
      for (int i = 0; i < NumDiv; i++) rem_q[i] <= '0;
    end else if (state_q == ifst_pkg::S_MOD) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      for (int i = 0; i < NumDiv; i++) rem_q[i] <= rem_nx[i];
    end
  end

`ifndef SYNTHESIS
  a_no_out_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ifst_pkg::S_MOD) |-> !in_stall_o == 1'b0)
    else $error("intake open during remainder");
  a_report_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && rep_q) |-> (st_q == ifst_pkg::ST_TAKEN))
    else $error("report without stamp");
  a_pulse_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ifst_pkg::S_OUT) |=> (out_v_q && st_q == ifst_pkg::ST_NONE))
    else $error("pulse result missing");
`endif

endmodule

// ===== tb/sv/tb_imu_frame_sync_trigger.sv =====
// Testbench for imu_frame_sync_trigger: directed table plus random byte frames and sync pulses,
// checked against a behavioral predictor. Depends on ifst_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_imu_frame_sync_trigger;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  ifst_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  ifst_pkg::out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_data;

  imu_frame_sync_trigger dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [15:0] div_m [ifst_pkg::NumRegs];
  logic [8:0]  pos_m;
  logic [7:0]  len_m, sum_m, id_m;
  logic [7:0]  head_m [5];
  logic [15:0] tick_m, wrap_m;
  logic [31:0] stamp_m;
  logic        pend_m;
  logic [6:0]  cam_m;
  logic        lidar_m;

  ifst_pkg::out_item_t expected_q [$];
  int errors;
  int unsigned cycles;
  bit hold_off;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic ifst_pkg::status_e close_frame();
    logic [15:0] t;
    if (sum_m != 8'd0) return ifst_pkg::ST_BAD_SUM;
    if (id_m != ifst_pkg::MsgTime) return ifst_pkg::ST_OTHER;
    if (len_m < 8'd5) return ifst_pkg::ST_SHORT;
    if (head_m[0] != ifst_pkg::Head0 || head_m[1] != ifst_pkg::Head1 ||
        head_m[2] != ifst_pkg::Head2) return ifst_pkg::ST_NOSTAMP;
    t = {head_m[3], head_m[4]};
    if (t < tick_m) wrap_m = wrap_m + 16'd1;
    tick_m = t;
    stamp_m = {wrap_m, t};
    return ifst_pkg::ST_TAKEN;
  endfunction

  function automatic ifst_pkg::out_item_t predict_trigger(input ifst_pkg::in_item_t it);
    ifst_pkg::out_item_t r;
    ifst_pkg::status_e st;
    logic [31:0] nxt, rem;
    logic rep;
    st = ifst_pkg::ST_NONE;
    rep = 1'b0;
    if (!it.req_type) begin
      pos_m = pos_m + 9'd1;
      if (pos_m >= 2) sum_m = sum_m + it.rx_byte;
      if (pos_m == 1) begin
        sum_m = 8'd0;
        if (it.rx_byte != ifst_pkg::Preamble0) pos_m = 9'd0;
      end else if (pos_m == 2) begin
        if (it.rx_byte != ifst_pkg::Preamble1) pos_m = 9'd0;
      end else if (pos_m == 3) begin
        id_m = it.rx_byte;
      end else if (pos_m == 4) begin
        len_m = it.rx_byte;
      end else begin
        if (pos_m - 5 < 5) head_m[pos_m - 5] = it.rx_byte;
        if ({1'b0, pos_m} >= 10'd5 + len_m) begin
          st = close_frame();
          if (st == ifst_pkg::ST_TAKEN && pend_m) begin
            pend_m = 1'b0;
            rep = 1'b1;
          end
          pos_m = 9'd0;
        end
      end
    end else begin
      nxt = stamp_m + 32'd1;
      for (int i = 0; i < 7; i++) begin
        if (div_m[i] != 16'd0) begin
          rem = nxt % div_m[i];
          if (rem == 0) cam_m[i] = 1'b1;
          else if (rem == 1) cam_m[i] = 1'b0;
        end
      end
      if (div_m[ifst_pkg::LidarReg] != 16'd0) begin
        rem = nxt % div_m[ifst_pkg::LidarReg];
        if (rem == 0) begin
          lidar_m = 1'b0;
          pend_m = 1'b1;
        end else if (rem == ifst_pkg::LidarHigh) begin
          lidar_m = 1'b1;
        end
      end
    end
    r.status = st;
    r.timestamp = stamp_m;
    r.report_due = rep;
    r.camera_lines = cam_m;
    r.lidar_line = lidar_m;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    ifst_pkg::out_item_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_item.timestamp, 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (out_item.status != w.status)
          report_mismatch("status", 32'(out_item.status), 32'(w.status));
        if (out_item.timestamp != w.timestamp)
          report_mismatch("timestamp", out_item.timestamp, w.timestamp);
        if (out_item.report_due != w.report_due)
          report_mismatch("report_due", 32'(out_item.report_due), 32'(w.report_due));
        if (out_item.camera_lines != w.camera_lines)
          report_mismatch("camera_lines", 32'(out_item.camera_lines), 32'(w.camera_lines));
        if (out_item.lidar_line != w.lidar_line)
          report_mismatch("lidar_line", 32'(out_item.lidar_line), 32'(w.lidar_line));
      end
    end
  end

  // receiver stall: random gaps, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk_i);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input ifst_pkg::in_item_t it);
    int gap;
    if ($urandom_range(0, 99) < 20) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    expected_q.push_back(predict_trigger(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_divisor(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    div_m[idx] = val;
    @(negedge clk_i);
  endtask

  function automatic ifst_pkg::in_item_t mk_byte(input logic [7:0] b);
    ifst_pkg::in_item_t it;
    it.req_type = 1'b0;
    it.rx_byte = b;
    return it;
  endfunction

  // send a frame; the length counts the payload, the checksum byte follows it
  task automatic send_frame(input logic [7:0] id, input logic [7:0] payload [$],
                            input bit corrupt);
    logic [7:0] s;
    s = ifst_pkg::Preamble1 + id + 8'(payload.size());
    foreach (payload[i]) s = s + payload[i];
    send_item(mk_byte(ifst_pkg::Preamble0));
    send_item(mk_byte(ifst_pkg::Preamble1));
    send_item(mk_byte(id));
    send_item(mk_byte(8'(payload.size())));
    foreach (payload[i]) send_item(mk_byte(payload[i]));
    send_item(mk_byte(corrupt ? 8'(-s + 1) : 8'(-s)));
  endtask

  task automatic send_tick_frame(input logic [15:0] t, input int extra);
    logic [7:0] p [$];
    p = '{ifst_pkg::Head0, ifst_pkg::Head1, ifst_pkg::Head2, t[15:8], t[7:0]};
    repeat (extra) p.push_back(8'($urandom));
    send_frame(ifst_pkg::MsgTime, p, 1'b0);
  endtask

  typedef struct {
    ifst_pkg::in_item_t it;
    bit                 chk;
    logic [2:0]         st;
  } row_t;

  initial begin
    row_t rows [$];
    logic [7:0] p [$];
    int kind;
    ifst_pkg::in_item_t it;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    for (int i = 0; i < 7; i++) div_m[i] = ifst_pkg::CamReset;
    div_m[ifst_pkg::LidarReg] = ifst_pkg::LidarRst;
    pos_m = '0; len_m = '0; sum_m = '0; id_m = '0;
    tick_m = '0; wrap_m = '0; stamp_m = '0; pend_m = 1'b0; cam_m = '0; lidar_m = 1'b0;
    foreach (head_m[i]) head_m[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: bad preamble, pulses, a frame cut short by a bad second byte, a short time frame
    rows = '{
      '{'{1'b0, 8'h00}, 1, ifst_pkg::ST_NONE}, '{'{1'b0, 8'hFF}, 1, ifst_pkg::ST_NONE},
      '{'{1'b1, 8'hFF}, 1, ifst_pkg::ST_NONE}, '{'{1'b0, 8'hFA}, 1, ifst_pkg::ST_NONE},
      '{'{1'b0, 8'hFA}, 1, ifst_pkg::ST_NONE}, '{'{1'b0, 8'hFA}, 1, ifst_pkg::ST_NONE},
      '{'{1'b0, 8'hFF}, 1, ifst_pkg::ST_NONE}, '{'{1'b0, 8'h36}, 0, ifst_pkg::ST_NONE},
      '{'{1'b0, 8'h00}, 0, ifst_pkg::ST_NONE}, '{'{1'b0, 8'hCB}, 1, ifst_pkg::ST_SHORT},
      '{'{1'b1, 8'h00}, 0, ifst_pkg::ST_NONE}
    };
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].chk) expected_q[$].status = rows[i].st;
    end
    send_frame(8'h12, '{8'h01}, 1'b0);        // other id
    send_frame(ifst_pkg::MsgTime, '{8'h10}, 1'b1);      // bad checksum
    send_frame(ifst_pkg::MsgTime, '{8'h10, 8'h20, 8'h03, 8'h00, 8'h01}, 1'b0); // no stamp
    send_tick_frame(16'hFFFF, 0);
    send_tick_frame(16'h0000, 0);             // tick goes down: wrap
    drain();

    // random phases through several divisor settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 8; r++) begin
        case (ph)
          0: write_divisor(3'(r), (r == ifst_pkg::LidarReg) ? 16'd11 : 16'd1);
          1: write_divisor(3'(r), 16'hFFFF);
          2: write_divisor(3'(r), 16'd0);
          3: write_divisor(3'(r), (r == ifst_pkg::LidarReg) ? 16'd10 : 16'(r + 2));
          default: write_divisor(3'(r), 16'($urandom_range(1, 40)));
        endcase
      end
      if (ph == 4) hold_off = 1'b1;
      for (int n = 0; n < 250; ) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          send_tick_frame(16'($urandom), $urandom_range(0, 3));
          n += 9;
        end else if (kind < 7) begin
          send_item('{1'b1, 8'($urandom)});
          n++;
        end else if (kind == 7) begin
          p = {};
          repeat ($urandom_range(0, 6)) p.push_back(8'($urandom));
          send_frame($urandom_range(0, 1) ? ifst_pkg::MsgTime : 8'($urandom), p,
                     $urandom_range(0, 1));
          n += p.size() + 5;
        end else begin
          it.req_type = 1'b0;
          it.rx_byte = $urandom_range(0, 1) ? ifst_pkg::Preamble0 : 8'($urandom);
          send_item(it);
          n++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
